FILE: hdl/ggpc_pkg.sv
package ggpc_pkg;

  // bearing pipeline depth, default
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;

  // field widths
  localparam int POS_W      = 24;
  localparam int HEAD_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int LIN_W      = 31;
  localparam int ANG_W      = 32;
  localparam int ERR_W      = POS_W + 1;   // goal minus pose

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_X       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_LINEAR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ANGULAR = 2'd3;
  localparam logic [GAIN_W-1:0]    GAIN_RESET       = 16'd256;

  // square root: one result bit per stage
  localparam int RAD_W       = 64;
  localparam int ROOT_W      = 32;
  localparam int REM_W       = ROOT_W + 2;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int SQ_SHIFT    = 14;

  // vectoring rotator
  localparam int CW          = 43;   // |v| * 1.647 stays below 2^42
  localparam int CORDIC_FRAC = 16;
  localparam int ZW          = 27;   // Q.24 angle
  localparam int AERR_W      = 28;   // heading error, Q.24
  localparam int HD_SHIFT    = 11;   // Q3.13 -> Q.24

  // output rounding
  localparam int LIN_SHIFT   = 7;
  localparam int ANG_SHIFT   = 16;

  localparam logic signed [ZW-1:0]     ANG_HALF_PI = 27'sd26353589;
  localparam logic signed [AERR_W-1:0] ANG_PI      = 28'sd52707179;
  localparam logic signed [AERR_W-1:0] ANG_NEG_PI  = -28'sd52707179;
  localparam logic signed [AERR_W-1:0] ANG_TWO_PI  = 28'sd105414357;

  localparam logic signed [ZW-1:0] ATAN_Q24 [ATAN_LEN] = '{
    27'sd13176795, 27'sd7778716, 27'sd4110060, 27'sd2086331,
    27'sd1047214,  27'sd524117,  27'sd262123,  27'sd131069,
    27'sd65536,    27'sd32768,   27'sd16384,   27'sd8192,
    27'sd4096,     27'sd2048,    27'sd1024,    27'sd512,
    27'sd256,      27'sd128,     27'sd64,      27'sd32,
    27'sd16,       27'sd8,       27'sd4,       27'sd2
  };

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [HEAD_W-1:0] heading;
  } pose_t;

  typedef struct packed {
    logic [LIN_W-1:0]        linear_speed;
    logic signed [ANG_W-1:0] angular_rate;
    logic                    saturated;
  } cmd_t;

  // state carried through the root / rotator stages
  typedef struct packed {
    logic [ROOT_W-1:0]        root;
    logic [REM_W-1:0]         rem;
    logic [RAD_W-1:0]         rad;
    logic signed [CW-1:0]     x;
    logic signed [CW-1:0]     y;
    logic signed [ZW-1:0]     z;
    logic signed [HEAD_W-1:0] hd;
    logic                     zero;
  } core_t;

endpackage

FILE: hdl/ggpc_front.sv
module ggpc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  ggpc_pkg::pose_t               pose_i,
  input  logic signed [ggpc_pkg::POS_W-1:0] goal_x_i,
  input  logic signed [ggpc_pkg::POS_W-1:0] goal_y_i,
  output logic                          valid_o,
  output ggpc_pkg::core_t               core_o
);
  import ggpc_pkg::*;

  // stage 1: error vector
  logic signed [ERR_W-1:0]  ex_d, ey_d, ex_q, ey_q;
  logic signed [HEAD_W-1:0] hd1_q, hd2_q;
  logic                     v1_q, v2_q, v3_q;

  // stage 2: squares and quadrant fold
  logic [ERR_W-1:0]         ax_full, ay_full;
  logic [2*POS_W-1:0]       sqx_d, sqy_d, sqx_q, sqy_q;
  logic signed [CW-1:0]     xe, ye, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0]     z_d, z_q;
  logic                     zero_d, zero_q;

  // stage 3: radicand
  logic [2*POS_W:0]         sum_sq;
  core_t                    core_d, core_q;

  assign ex_d = {goal_x_i[POS_W-1], goal_x_i} - {pose_i.pos_x[POS_W-1], pose_i.pos_x};
  assign ey_d = {goal_y_i[POS_W-1], goal_y_i} - {pose_i.pos_y[POS_W-1], pose_i.pos_y};

  // |e| < 2^24, so the magnitude fits the field width
  assign ax_full = ex_q[ERR_W-1] ? -ex_q : ex_q;
  assign ay_full = ey_q[ERR_W-1] ? -ey_q : ey_q;
  assign sqx_d   = ax_full[POS_W-1:0] * ax_full[POS_W-1:0];
  assign sqy_d   = ay_full[POS_W-1:0] * ay_full[POS_W-1:0];

  assign xe = {{(CW-ERR_W-CORDIC_FRAC){ex_q[ERR_W-1]}}, ex_q, {CORDIC_FRAC{1'b0}}};
  assign ye = {{(CW-ERR_W-CORDIC_FRAC){ey_q[ERR_W-1]}}, ey_q, {CORDIC_FRAC{1'b0}}};
  assign zero_d = (ex_q == '0) && (ey_q == '0);

  // left half plane: turn by a quarter first
  always_comb begin
    x_d = xe;
    y_d = ye;
    z_d = '0;
    if (xe[CW-1]) begin
      if (!ye[CW-1]) begin
        x_d = ye;
        y_d = -xe;
        z_d = ANG_HALF_PI;
      end else begin
        x_d = -ye;
        y_d = xe;
        z_d = -ANG_HALF_PI;
      end
    end
  end

  assign sum_sq = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_comb begin
    core_d      = '0;
    core_d.rad  = {{(RAD_W-2*POS_W-1-SQ_SHIFT){1'b0}}, sum_sq, {SQ_SHIFT{1'b0}}};
    core_d.x    = x_q;
    core_d.y    = y_q;
    core_d.z    = z_q;
    core_d.hd   = hd2_q;
    core_d.zero = zero_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ex_q   <= ex_d;
      ey_q   <= ey_d;
      hd1_q  <= pose_i.heading;
      sqx_q  <= sqx_d;
      sqy_q  <= sqy_d;
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      zero_q <= zero_d;
      hd2_q  <= hd1_q;
      core_q <= core_d;
    end
  end

  assign valid_o = v3_q;
  assign core_o  = core_q;

endmodule

FILE: hdl/ggpc_core_stage.sv
module ggpc_core_stage #(
  parameter int Idx          = 0,
  parameter int CordicStages = ggpc_pkg::CORDIC_STAGES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  ggpc_pkg::core_t core_i,
  output logic            valid_o,
  output ggpc_pkg::core_t core_o
);
  import ggpc_pkg::*;

  logic [REM_W+1:0]     rem_sh, trial, rem_sub;
  logic                 ge;
  logic signed [CW-1:0] x_in, y_in, x_nx, y_nx;
  logic signed [ZW-1:0] z_in, z_nx;
  core_t                core_d, core_q;
  logic                 valid_q;

  // one root bit: bring down two radicand bits, try (root << 2) | 1
  assign rem_sh  = {core_i.rem, core_i.rad[RAD_W-1 -: 2]};
  assign trial   = {{(REM_W-ROOT_W){1'b0}}, core_i.root, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;

  assign x_in = core_i.x;
  assign y_in = core_i.y;
  assign z_in = core_i.z;

  if (Idx < CordicStages && Idx < ATAN_LEN) begin : g_rot
    always_comb begin
      if (!y_in[CW-1]) begin
        x_nx = x_in + (y_in >>> Idx);
        y_nx = y_in - (x_in >>> Idx);
        z_nx = z_in + ATAN_Q24[Idx];
      end else begin
        x_nx = x_in - (y_in >>> Idx);
        y_nx = y_in + (x_in >>> Idx);
        z_nx = z_in - ATAN_Q24[Idx];
      end
    end
  end else begin : g_pass
    assign x_nx = x_in;
    assign y_nx = y_in;
    assign z_nx = z_in;
  end

  always_comb begin
    core_d      = core_i;
    core_d.root = {core_i.root[ROOT_W-2:0], ge};
    core_d.rem  = ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
    core_d.rad  = {core_i.rad[RAD_W-3:0], 2'b00};
    core_d.x    = x_nx;
    core_d.y    = y_nx;
    core_d.z    = z_nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      core_q <= core_d;
    end
  end

  assign valid_o = valid_q;
  assign core_o  = core_q;

endmodule

FILE: hdl/ggpc_back.sv
module ggpc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  ggpc_pkg::core_t                core_i,
  input  logic [ggpc_pkg::GAIN_W-1:0]    gain_lin_i,
  input  logic [ggpc_pkg::GAIN_W-1:0]    gain_ang_i,
  input  logic                           out_ready_i,
  output logic                           en_o,
  output logic                           out_valid_o,
  output ggpc_pkg::cmd_t                 out_data_o
);
  import ggpc_pkg::*;

  localparam int LIN_P_W = GAIN_W + ROOT_W;
  localparam int ANG_P_W = GAIN_W + AERR_W + 1;
  localparam int LIN_R_W = LIN_P_W + 1 - LIN_SHIFT;
  localparam int ANG_R_W = ANG_P_W - ANG_SHIFT;

  // heading error stage
  logic signed [ZW-1:0]     z_eff;
  logic signed [AERR_W-1:0] z_ext, hd_ext, diff, err_d, err_q;
  logic [ROOT_W-1:0]        dist_q;
  logic                     e_valid_q;

  // product stage
  logic [LIN_P_W-1:0]        lin_prod_d, lin_prod_q;
  logic signed [ANG_P_W-1:0] ang_prod_d, ang_prod_q;
  logic                      m_valid_q;

  // round, clip, output register
  logic [LIN_P_W:0]          lin_sum;
  logic [LIN_R_W-1:0]        lin_r;
  logic signed [ANG_P_W-1:0] ang_sum;
  logic                      lin_sat;
  cmd_t                      cmd_d, out_q;
  logic                      out_valid_q, out_load, en;

  assign z_eff  = core_i.zero ? '0 : core_i.z;
  assign z_ext  = {z_eff[ZW-1], z_eff};
  assign hd_ext = {{(AERR_W-HEAD_W-HD_SHIFT){core_i.hd[HEAD_W-1]}}, core_i.hd,
                   {HD_SHIFT{1'b0}}};
  assign diff   = z_ext - hd_ext;

  always_comb begin
    if (diff > ANG_PI) begin
      err_d = diff - ANG_TWO_PI;
    end else if (diff < ANG_NEG_PI) begin
      err_d = diff + ANG_TWO_PI;
    end else begin
      err_d = diff;
    end
  end

  assign lin_prod_d = gain_lin_i * dist_q;
  assign ang_prod_d = $signed({1'b0, gain_ang_i}) * err_q;

  assign lin_sum = {1'b0, lin_prod_q} + (LIN_P_W+1)'(1 << (LIN_SHIFT-1));
  assign lin_r   = lin_sum[LIN_P_W:LIN_SHIFT];
  assign lin_sat = |lin_r[LIN_R_W-1:LIN_W];
  assign ang_sum = ang_prod_q + ANG_P_W'(1 << (ANG_SHIFT-1));

  // |err| < 2^27 and gain < 2^16, so the turn rate never reaches the clip
  always_comb begin
    cmd_d.linear_speed = lin_sat ? {LIN_W{1'b1}} : lin_r[LIN_W-1:0];
    cmd_d.angular_rate = {{(ANG_W-ANG_R_W){ang_sum[ANG_P_W-1]}},
                          ang_sum[ANG_P_W-1:ANG_SHIFT]};
    cmd_d.saturated    = lin_sat;
  end

  // the pipeline freezes only when its last beat has nowhere to go
  assign out_load = !out_valid_q || out_ready_i;
  assign en       = !m_valid_q || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) begin
        e_valid_q <= valid_i;
        m_valid_q <= e_valid_q;
      end
      if (out_load) begin
        out_valid_q <= m_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      err_q      <= err_d;
      dist_q     <= core_i.root;
      lin_prod_q <= lin_prod_d;
      ang_prod_q <= ang_prod_d;
    end
    if (out_load && m_valid_q) begin
      out_q <= cmd_d;
    end
  end

  assign en_o        = en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_err_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_valid_q |-> (err_q <= ANG_PI) && (err_q >= ANG_NEG_PI))
    else $error("heading error left [-pi, pi] after wrap");

  a_sat_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.saturated |-> &out_q.linear_speed)
    else $error("saturated flag without clipped speed");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && out_load |=> out_valid_q)
    else $error("product stage beat not taken by output register");

endmodule

FILE: hdl/go_to_goal_p_controller.sv
// Go-to-goal proportional controller. Each input beat is a robot pose
// (x, y in signed Q16.8 m, heading in Q3.13 rad); each output beat is one
// command: linear speed = gain_linear * distance to goal, and angular rate =
// gain_angular * (bearing - heading) wrapped into [-pi, pi], both Q16.16
// with the speed clipped to 2^31-1 (saturated flags the clip). The user must
// write the goal and gains through the cfg port only while no beat is in
// flight; this is not enforced. The gains reset to 1.0 and the goal to the
// origin. The block is fully pipelined: a new pose is taken every cycle while
// in_ready_o is high, and each command passes 3 front stages, 32 square-root
// stages that also carry the CORDIC_STAGES vectoring steps, 2 error/product
// stages and the output register. The depth is set by the one-bit-per-stage
// root of the 64-bit squared distance. When the output is held off, the
// output register keeps its beat and the rest of the pipeline keeps accepting
// until the last product stage is full; only then does in_ready_o drop.
module go_to_goal_p_controller #(
  parameter int CORDIC_STAGES = ggpc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ggpc_pkg::pose_t                   in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ggpc_pkg::cmd_t                    out_data_o,
  input  logic                              cfg_we_i,
  input  logic [ggpc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ggpc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import ggpc_pkg::*;

  // configuration registers
  logic signed [POS_W-1:0] goal_x_q, goal_y_q;
  logic [GAIN_W-1:0]       gain_lin_q, gain_ang_q;

  // stage chain: entry k feeds root/rotator stage k
  core_t                   core_s [SQRT_STAGES+1];
  logic [SQRT_STAGES:0]    vld_s;
  logic                    en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q   <= '0;
      goal_y_q   <= '0;
      gain_lin_q <= GAIN_RESET;
      gain_ang_q <= GAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GOAL_X:       goal_x_q   <= cfg_wdata_i[POS_W-1:0];
        REG_GOAL_Y:       goal_y_q   <= cfg_wdata_i[POS_W-1:0];
        REG_GAIN_LINEAR:  gain_lin_q <= cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_ANGULAR: gain_ang_q <= cfg_wdata_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // error vector, squares, quadrant fold, radicand
  ggpc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .pose_i   (in_data_i),
    .goal_x_i (goal_x_q),
    .goal_y_i (goal_y_q),
    .valid_o  (vld_s[0]),
    .core_o   (core_s[0])
  );

  // one root bit per stage; the first CORDIC_STAGES, at most ATAN_LEN, also rotate
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_core
    ggpc_core_stage #(
      .Idx          (k),
      .CordicStages (CORDIC_STAGES)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld_s[k]),
      .core_i  (core_s[k]),
      .valid_o (vld_s[k+1]),
      .core_o  (core_s[k+1])
    );
  end

  // heading error, gain products, rounding, clip, output register
  ggpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (vld_s[SQRT_STAGES]),
    .core_i      (core_s[SQRT_STAGES]),
    .gain_lin_i  (gain_lin_q),
    .gain_ang_i  (gain_ang_q),
    .out_ready_i (out_ready_i),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  assign in_ready_o = en;

  // input is held off only while the output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output free");

  // an accepted pose reaches the first chain entry
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o ##1 in_ready_o ##1 in_ready_o |=> vld_s[0])
    else $error("accepted pose lost in front stages");

  // last chain entry is never dropped by the back end
  a_tail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_s[SQRT_STAGES] && !en |=> vld_s[SQRT_STAGES] && $stable(core_s[SQRT_STAGES]))
    else $error("chain tail changed during stall");

endmodule

FILE: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ggpc_pkg::*;

  // Pose in, command out.
  localparam int STAGES      = CORDIC_STAGES_DEF;
  localparam int LATENCY     = 38;
  localparam int HOLD_CYCLES = 400;      // long receiver hold-off
  localparam int LIMIT       = 500000;   // watchdog, in cycles
  localparam int PHASE_POSES = 200;
  localparam int NUM_PHASES  = 7;
  localparam int POS_MAX     = 8388607;
  localparam int POS_MIN     = -8388608;
  localparam int HEAD_LIM    = 25736;    // pi in Q3.13

  // Angle constants in Q.24 radians
  localparam longint HALF_PI_Q24 = 26353589;
  localparam longint PI_Q24      = 52707179;
  localparam longint TWO_PI_Q24  = 105414357;
  localparam longint ATAN_TBL [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  logic                  clk_i;
  logic                  rst_ni     = 1'b0;
  logic                  pose_valid = 1'b0;
  logic                  pose_ready;
  pose_t                 pose_data  = '0;
  logic                  cmd_valid;
  logic                  cmd_ready  = 1'b0;
  cmd_t                  cmd_data;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // Shadow copy of the register file, as the predictor sees it
  logic signed [POS_W-1:0] goal_x_q   = '0;
  logic signed [POS_W-1:0] goal_y_q   = '0;
  logic [GAIN_W-1:0]       gain_lin_q = GAIN_RESET;
  logic [GAIN_W-1:0]       gain_ang_q = GAIN_RESET;

  pose_t pose_q[$];   // poses waiting to be driven
  cmd_t  cmd_q[$];    // predicted commands, oldest first

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;   // bumped by the sequencer to start a hold-off
  int hold_seen      = 0;
  int hold_left      = 0;
  int cmd_errors     = 0;
  int cycles         = 0;

  go_to_goal_p_controller #(
    .CORDIC_STAGES (STAGES)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pose_valid),
    .in_ready_o  (pose_ready),
    .in_data_i   (pose_data),
    .out_valid_o (cmd_valid),
    .out_ready_i (cmd_ready),
    .out_data_o  (cmd_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Expected command for one pose under the current goal and gains.
  // Distance: exact integer root of the squared error, Q.15.
  // Bearing: vectoring rotation, Q.24, with a quarter-turn pre-rotation
  // for vectors in the left half plane.
  function automatic cmd_t predict_cmd(pose_t p);
    longint ex, ey, hd, x, y, z, xs, ys, t, err, ang;
    longint unsigned ax, ay, rad, root, probe, lin;
    logic sat;
    cmd_t c;
    ex  = longint'(goal_x_q) - longint'($signed(p.pos_x));
    ey  = longint'(goal_y_q) - longint'($signed(p.pos_y));
    hd  = longint'($signed(p.heading));
    ax  = (ex < 0) ? -ex : ex;
    ay  = (ey < 0) ? -ey : ey;
    rad = (ax * ax + ay * ay) << 14;

    // bit-by-bit square root
    root  = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rad) probe >>= 2;
    while (probe != 0) begin
      if (rad >= root + probe) begin
        rad  = rad - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end

    z = 0;
    if (ex != 0 || ey != 0) begin
      x = ex * 65536;
      y = ey * 65536;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = HALF_PI_Q24;
        end else begin
          x = -y;
          y = t;
          z = -HALF_PI_Q24;
        end
      end
      for (int i = 0; i < STAGES && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_TBL[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_TBL[i];
        end
      end
    end

    sat = 1'b0;
    lin = (longint'(gain_lin_q) * root + 64) >> 7;
    if (lin > 64'h7FFF_FFFF) begin
      lin = 64'h7FFF_FFFF;
      sat = 1'b1;
    end

    // heading error, one wrap step into [-pi, pi]
    err = z - hd * 2048;
    if (err > PI_Q24) err = err - TWO_PI_Q24;
    else if (err < -PI_Q24) err = err + TWO_PI_Q24;
    ang = (longint'(gain_ang_q) * err + 32768) >>> 16;
    if (ang > 64'sd2147483647) begin
      ang = 64'sd2147483647;
      sat = 1'b1;
    end else if (ang < -64'sd2147483648) begin
      ang = -64'sd2147483648;
      sat = 1'b1;
    end

    c.linear_speed = lin[LIN_W-1:0];
    c.angular_rate = ang[ANG_W-1:0];
    c.saturated    = sat;
    return c;
  endfunction

  // Pose driver: keeps valid and payload stable until the beat is taken,
  // predicts the command of every accepted pose.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_valid <= 1'b0;
      pose_data  <= '0;
    end else begin
      if (pose_valid && pose_ready) cmd_q.push_back(predict_cmd(pose_data));
      if (!pose_valid || pose_ready) begin
        if (pose_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pose_valid <= 1'b1;
          pose_data  <= pose_q.pop_front();
        end else begin
          pose_valid <= 1'b0;
        end
      end
    end
  end

  // Hold-off counter, runs on its own so the sender keeps pushing while
  // the output is blocked and the pipeline backs up to in_ready.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Command monitor: field-by-field compare against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_ready <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin : check_beat
        cmd_t want;
        if (cmd_q.size() == 0) begin
          if (cmd_errors < 10)
            $display("unexpected command beat: lin=%0d ang=%0d sat=%0b",
                     cmd_data.linear_speed, $signed(cmd_data.angular_rate),
                     cmd_data.saturated);
          cmd_errors <= cmd_errors + 1;
        end else begin
          want = cmd_q.pop_front();
          if (cmd_data.linear_speed !== want.linear_speed ||
              cmd_data.angular_rate !== want.angular_rate ||
              cmd_data.saturated !== want.saturated) begin
            if (cmd_errors < 10)
              $display("command mismatch: exp lin=%0d ang=%0d sat=%0b, got lin=%0d ang=%0d sat=%0b",
                       want.linear_speed, $signed(want.angular_rate), want.saturated,
                       cmd_data.linear_speed, $signed(cmd_data.angular_rate),
                       cmd_data.saturated);
            cmd_errors <= cmd_errors + 1;
          end
        end
      end
      cmd_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Register write; the shadow copy keeps only the register's own width.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_GOAL_X:       goal_x_q   = data[POS_W-1:0];
      REG_GOAL_Y:       goal_y_q   = data[POS_W-1:0];
      REG_GAIN_LINEAR:  gain_lin_q = data[GAIN_W-1:0];
      REG_GAIN_ANGULAR: gain_ang_q = data[GAIN_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic add_pose(input int px, input int py, input int hd);
    pose_t p;
    p.pos_x   = POS_W'(px);
    p.pos_y   = POS_W'(py);
    p.heading = HEAD_W'(hd);
    pose_q.push_back(p);
  endtask

  // Block is idle once every pose is taken and every command is back;
  // then let the pipeline run out before touching the registers.
  task automatic wait_idle();
    while (pose_q.size() != 0 || pose_valid || cmd_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  // Short error vectors around the goal most often (where the rotator and the
  // root do their finest work), some on an axis, some wide open, some
  // with a heading outside [-pi, pi].
  task automatic queue_random_poses(input int count);
    pose_t p;
    int kind, dx, dy;
    for (int n = 0; n < count; n++) begin
      kind      = $urandom_range(99);
      p.pos_x   = POS_W'($urandom);
      p.pos_y   = POS_W'($urandom);
      p.heading = HEAD_W'(int'($urandom_range(2 * HEAD_LIM)) - HEAD_LIM);
      if (kind < 40) begin
        dx = int'($urandom_range(8192)) - 4096;
        dy = int'($urandom_range(8192)) - 4096;
        if (kind < 6) dx = 0;
        else if (kind < 12) dy = 0;
        else if (kind < 20) begin
          dx = dx >>> 10;
          dy = dy >>> 10;
        end
        p.pos_x = POS_W'(int'(goal_x_q) - dx);
        p.pos_y = POS_W'(int'(goal_y_q) - dy);
      end else if (kind < 55) begin
        if (kind[0]) p.pos_x = goal_x_q;
        else p.pos_y = goal_y_q;
      end else if (kind < 65) begin
        p.heading = HEAD_W'($urandom);
      end
      pose_q.push_back(p);
    end
  endtask

  // Sequencer
  initial begin
    int mode;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: goal at the origin, both gains 1.0
    add_pose(0, 0, 0);                    // goal reached, bearing zero
    add_pose(0, 0, HEAD_LIM);
    add_pose(0, 0, -HEAD_LIM);
    add_pose(0, 0, 32767);                // heading past +pi
    add_pose(0, 0, -32768);               // heading past -pi
    add_pose(-256, 0, 0);                 // goal straight ahead
    add_pose(256, 0, -HEAD_LIM);          // goal behind, error wraps
    add_pose(256, 256, HEAD_LIM);         // third quadrant, wraps upward
    add_pose(0, -256, -HEAD_LIM);         // goal to the left, wraps down
    add_pose(POS_MAX, POS_MAX, 0);
    add_pose(POS_MIN, POS_MIN, 1);
    add_pose(POS_MAX, POS_MIN, -1);
    add_pose(POS_MIN, POS_MAX, 12000);
    wait_idle();

    // Goal in a far corner, gains at full scale (upper data bits set)
    write_reg(REG_GOAL_X, POS_W'(POS_MAX));
    write_reg(REG_GOAL_Y, POS_W'(POS_MIN));
    write_reg(REG_GAIN_LINEAR, 24'hFFFFFF);
    write_reg(REG_GAIN_ANGULAR, 24'hFFFFFF);
    add_pose(POS_MIN, POS_MAX, 0);        // longest distance, speed clips
    add_pose(POS_MAX, POS_MIN, 0);        // on the goal
    add_pose(0, 0, -32768);
    add_pose(POS_MAX - 1, POS_MIN + 1, 100);
    wait_idle();

    // Zero gains, goal in the opposite corner
    write_reg(REG_GOAL_X, POS_W'(POS_MIN));
    write_reg(REG_GOAL_Y, POS_W'(POS_MAX));
    write_reg(REG_GAIN_LINEAR, 24'hFF0000);
    write_reg(REG_GAIN_ANGULAR, 24'hFF0000);
    add_pose(POS_MAX, POS_MIN, 12345);
    add_pose(0, 0, -100);
    add_pose(POS_MIN, POS_MAX, 0);
    wait_idle();

    // Random phases, cycling through the idling modes:
    // none, sender idle, receiver stalling, both.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      mode = ph % 4;
      write_reg(REG_GOAL_X, CFG_DATA_W'($urandom));
      write_reg(REG_GOAL_Y, CFG_DATA_W'($urandom));
      write_reg(REG_GAIN_LINEAR, ($urandom_range(2) == 0) ?
                CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(1024)));
      write_reg(REG_GAIN_ANGULAR, ($urandom_range(2) == 0) ?
                CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(1024)));
      send_idle_pct  = (mode == 1) ? 73 : (mode == 3) ? 21 : 0;
      recv_stall_pct = (mode == 2) ? 73 : (mode == 3) ? 21 : 0;
      queue_random_poses(PHASE_POSES);
      // back-pressure test: output blocked while poses keep coming
      if (ph == 0) hold_req = hold_req + 1;
      wait_idle();
    end

    if (cmd_q.size() != 0) cmd_errors = cmd_errors + 1;
    if (cmd_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
